// ===== design/assert_macros.svh =====
// Assertion macros for the checker file gbz_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, reset masked
`define GBZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, reset masked
`define GBZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/gbz_pkg.sv =====
// Shared types and constants for the grid bilinear Z correction block.
// No dependencies; imported by gbz_grid, gbz_muldiv and the top module.
package gbz_pkg;
  localparam int GBZ_SIDE_MAX = 16;

  localparam logic [2:0] CFG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_X_ORIGIN   = 3'd1;
  localparam logic [2:0] CFG_X_CELL     = 3'd2;
  localparam logic [2:0] CFG_Y_ORIGIN   = 3'd3;
  localparam logic [2:0] CFG_Y_CELL     = 3'd4;
  localparam logic [2:0] CFG_POINTS     = 3'd5;
  localparam logic [2:0] CFG_FADE_START = 3'd6;
  localparam logic [2:0] CFG_FADE_END   = 3'd7;

  // result of the shared multiply-divide unit: |a|*b / d, sign of a apart
  typedef struct packed {
    logic        done;
    logic        neg;
    logic [63:0] q;
    logic [31:0] r;
  } md_res_t;
endpackage

// ===== design/gbz_grid.sv =====
// Correction table memory: one write port, one registered read port.
// Sweeps every entry to zero after reset. Depends on gbz_pkg.
module gbz_grid #(
  parameter int SIDE = gbz_pkg::GBZ_SIDE_MAX
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [$clog2(SIDE*SIDE)-1:0]          wr_addr,
  input  logic [31:0]                           wr_data,
  input  logic                                  rd_en,
  input  logic [$clog2(SIDE*SIDE)-1:0]          rd_addr,
  output logic [31:0]                           rd_data,
  output logic                                  clearing
);
  import gbz_pkg::*;
  localparam int AW = $clog2(SIDE*SIDE);
  localparam logic [AW-1:0] LAST = AW'(SIDE*SIDE-1);

  logic [31:0]   mem [SIDE*SIDE];
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;
  logic [31:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;
endmodule

// ===== design/gbz_muldiv.sv =====
// Bit-serial unit: multiplies |a| by b, then divides by d (restoring).
// 32 multiply steps, 64 divide steps. Depends on gbz_pkg.
module gbz_muldiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [32:0]    a,
  input  logic [31:0]           b,
  input  logic [31:0]           d,
  output gbz_pkg::md_res_t      res
);
  import gbz_pkg::*;
  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_DONE} mstate_t;

  mstate_t     state_r;
  logic [32:0] mag_r;
  logic [31:0] b_r;
  logic [31:0] d_r;
  logic [63:0] p_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic [32:0] sh;
  logic [32:0] sub;

  assign sh  = {rem_r, p_r[63]};
  assign sub = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      case (state_r)
        M_IDLE: if (start) begin
          neg_r   <= a[32];
          mag_r   <= a[32] ? 33'(-a) : 33'(a);
          b_r     <= b;
          d_r     <= d;
          p_r     <= '0;
          cnt_r   <= 6'd31;
          state_r <= M_MUL;
        end
        M_MUL: begin
          p_r <= {p_r[62:0], 1'b0} + (b_r[31] ? {31'd0, mag_r} : 64'd0);
          b_r <= {b_r[30:0], 1'b0};
          if (cnt_r == 6'd0) begin
            cnt_r   <= 6'd63;
            rem_r   <= '0;
            state_r <= M_DIV;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        M_DIV: begin
          if (!sub[32]) begin
            rem_r <= sub[31:0];
            p_r   <= {p_r[62:0], 1'b1};
          end else begin
            rem_r <= sh[31:0];
            p_r   <= {p_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_r <= M_DONE;
        end
        M_DONE: state_r <= M_IDLE;
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign res.done = (state_r == M_DONE);
  assign res.neg  = neg_r;
  assign res.q    = p_r;
  assign res.r    = rem_r;
endmodule

// ===== design/grid_bilinear_z_correction.sv =====
// Grid bilinear Z correction: write items fill the table, query items return one result.
// A query runs up to six multiply-divide passes, four table reads and an output stage;
// a zeroed query goes straight to the output stage. One item in flight.
// Reset: synchronous active-low; registers to defaults, then a clear of every table entry,
// during which no item is taken. Depends on gbz_pkg, gbz_grid, gbz_muldiv.
module grid_bilinear_z_correction #(
  parameter int GRID_SIDE_MAX = gbz_pkg::GBZ_SIDE_MAX
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, probe_active, entry_col, entry_row, entry_value, pad
  input  logic [143:0] in_tdata,
  // kind
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // z_correction
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import gbz_pkg::*;
  localparam int AW  = $clog2(GRID_SIDE_MAX*GRID_SIDE_MAX);
  localparam int CW  = $clog2(GRID_SIDE_MAX);
  localparam int PTW = $clog2(GRID_SIDE_MAX+1);

  typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_READ, S_OUT} state_t;
  typedef enum logic [2:0] {OP_LX, OP_LY, OP_I1, OP_I2, OP_I3, OP_FD} op_t;

  logic               en_r;
  logic signed [31:0] xo_r, yo_r, fs_r, fe_r;
  logic [30:0]        xc_r, yc_r;
  logic [4:0]         gp_r;

  state_t             state_r;
  op_t                op_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [CW-1:0]      cx_r, cy_r;
  logic [30:0]        fx_r, fy_r;
  logic [31:0]        m_r [4];
  logic [31:0]        zx1_r, zx2_r, v_r;
  logic [2:0]         k_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic               in_acc;
  logic               clearing;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic               rd_en;
  logic [31:0]        rd_data;
  logic               md_start;
  logic signed [32:0] md_a;
  logic [31:0]        md_b, md_d;
  md_res_t            md_res;
  logic [30:0]        dx_eff, dy_eff, loc_d;
  logic [PTW-1:0]     pts;
  logic [CW-1:0]      loc_c;
  logic [30:0]        loc_f;
  logic [31:0]        tq;
  logic signed [31:0] in_pz;

  assign in_tready  = (state_r == S_IDLE) && !clearing;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_pz      = $signed(in_tdata[95:64]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
      xo_r <= '0;
      xc_r <= 31'd1;
      yo_r <= '0;
      yc_r <= 31'd1;
      gp_r <= 5'd2;
      fs_r <= '0;
      fe_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:     en_r <= cfg_data[0];
        CFG_X_ORIGIN:   xo_r <= cfg_data;
        CFG_X_CELL:     xc_r <= cfg_data[30:0];
        CFG_Y_ORIGIN:   yo_r <= cfg_data;
        CFG_Y_CELL:     yc_r <= cfg_data[30:0];
        CFG_POINTS:     gp_r <= cfg_data[4:0];
        CFG_FADE_START: fs_r <= cfg_data;
        CFG_FADE_END:   fe_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dx_eff = (xc_r == '0) ? 31'd1 : xc_r;
  assign dy_eff = (yc_r == '0) ? 31'd1 : yc_r;
  assign pts = (gp_r < 5'd2) ? PTW'(2) :
               ((32'(gp_r) > 32'(GRID_SIDE_MAX)) ? PTW'(GRID_SIDE_MAX) : PTW'(gp_r));
  assign loc_d = (op_r == OP_LY) ? dy_eff : dx_eff;

  always_comb begin
    if (md_res.neg) begin
      loc_c = '0;
      loc_f = '0;
    end else if (md_res.q >= 64'(pts - PTW'(1))) begin
      loc_c = CW'(pts - PTW'(2));
      loc_f = loc_d;
    end else begin
      loc_c = md_res.q[CW-1:0];
      loc_f = md_res.r[30:0];
    end
  end

  assign tq = md_res.neg ? (32'd0 - md_res.q[31:0]) : md_res.q[31:0];

  always_comb begin
    md_a = '0;
    md_b = 32'd1;
    md_d = {1'b0, dx_eff};
    case (op_r)
      OP_LX: md_a = {px_r[31], px_r} - {xo_r[31], xo_r};
      OP_LY: begin
        md_a = {py_r[31], py_r} - {yo_r[31], yo_r};
        md_d = {1'b0, dy_eff};
      end
      OP_I1: begin
        md_a = {m_r[1][31], m_r[1]} - {m_r[0][31], m_r[0]};
        md_b = {1'b0, fx_r};
      end
      OP_I2: begin
        md_a = {m_r[3][31], m_r[3]} - {m_r[2][31], m_r[2]};
        md_b = {1'b0, fx_r};
      end
      OP_I3: begin
        md_a = {zx2_r[31], zx2_r} - {zx1_r[31], zx1_r};
        md_b = {1'b0, fy_r};
        md_d = {1'b0, dy_eff};
      end
      OP_FD: begin
        md_a = {v_r[31], v_r};
        md_b = fe_r - pz_r;
        md_d = fe_r - fs_r;
      end
      default: ;
    endcase
  end

  assign md_start = (state_r == S_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_LX;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_acc && in_tuser[0]) begin
          px_r <= $signed(in_tdata[31:0]);
          py_r <= $signed(in_tdata[63:32]);
          pz_r <= in_pz;
          if (!en_r || in_tdata[96] || (in_pz > fe_r)) begin
            v_r     <= '0;
            state_r <= S_OUT;
          end else begin
            op_r    <= OP_LX;
            state_r <= S_START;
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: if (md_res.done) begin
          case (op_r)
            OP_LX: begin
              cx_r    <= loc_c;
              fx_r    <= loc_f;
              op_r    <= OP_LY;
              state_r <= S_START;
            end
            OP_LY: begin
              cy_r    <= loc_c;
              fy_r    <= loc_f;
              k_r     <= '0;
              state_r <= S_READ;
            end
            OP_I1: begin
              zx1_r   <= m_r[0] + tq;
              op_r    <= OP_I2;
              state_r <= S_START;
            end
            OP_I2: begin
              zx2_r   <= m_r[2] + tq;
              op_r    <= OP_I3;
              state_r <= S_START;
            end
            OP_I3: begin
              v_r <= zx1_r + tq;
              if ((pz_r > fs_r) && (pz_r > 32'sd0)) begin
                op_r    <= OP_FD;
                state_r <= S_START;
              end else begin
                state_r <= S_OUT;
              end
            end
            OP_FD: begin
              v_r     <= tq;
              state_r <= S_OUT;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_READ: begin
          if (k_r != 3'd0) m_r[k_r[1:0] - 2'd1] <= rd_data;
          k_r <= k_r + 3'd1;
          if (k_r == 3'd4) begin
            op_r    <= OP_I1;
            state_r <= S_START;
          end
        end
        S_OUT: if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          out_data_r  <= v_r;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign wr_en = in_acc && !in_tuser[0] &&
                 (32'(in_tdata[100:97]) < 32'(GRID_SIDE_MAX)) &&
                 (32'(in_tdata[104:101]) < 32'(GRID_SIDE_MAX));
  assign wr_addr = AW'(in_tdata[104:101]) * AW'(GRID_SIDE_MAX) + AW'(in_tdata[100:97]);
  assign rd_en   = (state_r == S_READ) && !k_r[2];
  assign rd_addr = (AW'(cy_r) + AW'(k_r[1])) * AW'(GRID_SIDE_MAX) + AW'(cx_r) + AW'(k_r[0]);

  gbz_grid #(.SIDE(GRID_SIDE_MAX)) u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_tdata[136:105]),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  gbz_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .res   (md_res)
  );
endmodule

// ===== design/gbz_checker.sv =====
// Port-level checker for grid_bilinear_z_correction, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module gbz_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  `GBZ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `GBZ_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  `GBZ_ASSERT_NEXT(a_wr_no_result, in_tvalid && in_tready && !in_tuser[0] && !out_tvalid,
    !out_tvalid, "write made a result")
  `GBZ_ASSERT_NEXT(a_query_busy, in_tvalid && in_tready && in_tuser[0], !in_tready,
    "query overlapped")
endmodule

bind grid_bilinear_z_correction gbz_checker u_gbz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/tb_grid_bilinear_z_correction.sv =====
// Testbench for grid_bilinear_z_correction: drives table writes and correction queries
// over the stream ports, predicts each correction in wide integers and checks results.
// Depends on gbz_pkg and the block's RTL.
module tb_grid_bilinear_z_correction;
  import gbz_pkg::*;

  localparam int SIDE = GBZ_SIDE_MAX;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  grid_bilinear_z_correction dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] mesh [SIDE*SIDE];
  logic               p_enable;
  longint             p_x_org, p_x_cell, p_y_org, p_y_cell, p_pts, p_fade_lo, p_fade_hi;

  logic [31:0] corrections_due [$];
  int  errors = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  rx_holdoff = 0;

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if (a % d != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic void cell_of(longint pos, longint org, longint d,
                                  output longint c, output longint f);
    longint rel;
    rel = pos - org;
    c = floor_quot(rel, d);
    f = rel - c * d;
    if (c < 0) begin
      c = 0;
      f = 0;
    end else if (c >= p_pts - 1) begin
      c = p_pts - 2;
      f = d;
    end
  endfunction

  function automatic logic [31:0] z_correction_of(logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz, logic probe);
    longint cx, fx, cy, fy, dx, dy, m11, m12, m21, m22, zx1, zx2, v;
    int base;
    if (!p_enable || probe) return 32'd0;
    if (longint'(pz) > p_fade_hi) return 32'd0;
    dx = (p_x_cell == 0) ? 1 : p_x_cell;
    dy = (p_y_cell == 0) ? 1 : p_y_cell;
    cell_of(px, p_x_org, dx, cx, fx);
    cell_of(py, p_y_org, dy, cy, fy);
    base = int'(cy) * SIDE + int'(cx);
    m11 = mesh[base];
    m12 = mesh[base + 1];
    m21 = mesh[base + SIDE];
    m22 = mesh[base + SIDE + 1];
    zx1 = m11 + ((m12 - m11) * fx) / dx;
    zx2 = m21 + ((m22 - m21) * fx) / dx;
    v = zx1 + ((zx2 - zx1) * fy) / dy;
    // exact product, truncating division
    if (longint'(pz) > p_fade_lo && pz > 0)
      v = longint'((128'(signed'(v)) * 128'(signed'(p_fade_hi - pz)))
                   / 128'(signed'(p_fade_hi - p_fade_lo)));
    return v[31:0];
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLE:     p_enable  = val[0];
      CFG_X_ORIGIN:   p_x_org   = longint'(signed'(val));
      CFG_X_CELL:     p_x_cell  = val[30:0];
      CFG_Y_ORIGIN:   p_y_org   = longint'(signed'(val));
      CFG_Y_CELL:     p_y_cell  = val[30:0];
      CFG_POINTS:     begin
        p_pts = val[4:0];
        if (p_pts < 2) p_pts = 2;
        if (p_pts > SIDE) p_pts = SIDE;
      end
      CFG_FADE_START: p_fade_lo = longint'(signed'(val));
      CFG_FADE_END:   p_fade_hi = longint'(signed'(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  // sends one item, after a random idle gap when tx_idle_on; tvalid stays high across back-to-back transfers
  task automatic send_item(logic kind, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic probe, logic [3:0] col, logic [3:0] row,
                           logic [31:0] value);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= {7'd0, value, row, col, probe, pz, py, px};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_WRITE) mesh[int'(row) * SIDE + int'(col)] = value;
    else corrections_due.push_back(z_correction_of(px, py, pz, probe));
  endtask

  task automatic drain();
    int n;
    in_tvalid <= 1'b0;
    n = 0;
    while (corrections_due.size() != 0 && n < 2000000) begin
      @(posedge clk);
      n++;
    end
    repeat (700) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (corrections_due.size() == 0) begin
        $error("unexpected z_correction transfer: %0d", $signed(out_tdata));
        errors++;
      end else begin
        if (out_tdata !== corrections_due[0]) begin
          $error("z_correction mismatch: expected %0d actual %0d",
                 $signed(corrections_due[0]), $signed(out_tdata));
          errors++;
        end
        void'(corrections_due.pop_front());
      end
    end
  end

  // receiver: random stall bursts, or a long hold-off on request
  always @(posedge clk) begin
    if (rx_holdoff > 0) begin
      out_tready <= 1'b0;
      rx_holdoff <= rx_holdoff - 1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      rx_holdoff <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_query(int span);
    logic [31:0] px, py, pz;
    if ($urandom_range(0, 9) == 0) begin
      px = pick32();
      py = pick32();
    end else begin
      px = 32'(p_x_org + (p_x_cell == 0 ? 1 : p_x_cell) * ($urandom_range(0, span) - 2)
                + $urandom_range(0, 3));
      py = 32'(p_y_org + (p_y_cell == 0 ? 1 : p_y_cell) * ($urandom_range(0, span) - 2)
                + $urandom_range(0, 3));
    end
    case ($urandom_range(0, 4))
      0: pz = pick32();
      1: pz = 32'(p_fade_lo + $urandom_range(0, 20) - 5);
      2: pz = 32'(p_fade_hi + $urandom_range(0, 4) - 2);
      default: pz = 32'(p_fade_lo + (p_fade_hi - p_fade_lo) / 2);
    endcase
    send_item(KIND_QUERY, px, py, pz, $urandom_range(0, 9) == 0, 4'($urandom()),
              4'($urandom()), $urandom());
  endtask

  task automatic fill_mesh(int mode);
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        send_item(KIND_WRITE, $urandom(), $urandom(), $urandom(), 1'($urandom()),
                  4'(c), 4'(r), mode == 0 ? pick32() : 32'($signed($urandom_range(0, 4000)) - 2000));
  endtask

  task automatic test_reset_defaults();
    send_item(KIND_QUERY, 32'd0, 32'd0, 32'd0, 1'b0, '0, '0, '0);
    send_item(KIND_WRITE, '0, '0, '0, 1'b0, 4'd15, 4'd15, 32'h7fff_ffff);
    send_item(KIND_QUERY, 32'd5, 32'd5, 32'd0, 1'b0, '0, '0, '0);
    drain();
  endtask

  task automatic test_directed();
    cfg_write(CFG_ENABLE, 32'd1);
    cfg_write(CFG_X_ORIGIN, 32'd100);
    cfg_write(CFG_X_CELL, 32'd10);
    cfg_write(CFG_Y_ORIGIN, -32'sd50);
    cfg_write(CFG_Y_CELL, 32'd7);
    cfg_write(CFG_POINTS, 32'd3);
    cfg_write(CFG_FADE_START, 32'd100);
    cfg_write(CFG_FADE_END, 32'd200);
    send_item(KIND_WRITE, '0, '0, '0, 1'b0, 4'd0, 4'd0, 32'h8000_0000);
    send_item(KIND_WRITE, '0, '0, '0, 1'b0, 4'd1, 4'd0, 32'h7fff_ffff);
    send_item(KIND_WRITE, '0, '0, '0, 1'b0, 4'd0, 4'd1, -32'sd1000);
    send_item(KIND_WRITE, '0, '0, '0, 1'b0, 4'd1, 4'd1, 32'd999);
    send_item(KIND_WRITE, '0, '0, '0, 1'b0, 4'd2, 4'd2, 32'd77);
    // inside, below grid, above grid, exact node
    send_item(KIND_QUERY, 32'd103, -32'sd47, 32'd0, 1'b0, '0, '0, '0);
    send_item(KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, '0, '0);
    send_item(KIND_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 32'd50, 1'b0, '0, '0, '0);
    send_item(KIND_QUERY, 32'd110, -32'sd43, 32'd100, 1'b0, '0, '0, '0);
    // probing, fade zone, fade end, above fade end
    send_item(KIND_QUERY, 32'd105, -32'sd45, 32'd0, 1'b1, '0, '0, '0);
    send_item(KIND_QUERY, 32'd105, -32'sd45, 32'd150, 1'b0, '0, '0, '0);
    send_item(KIND_QUERY, 32'd105, -32'sd45, 32'd200, 1'b0, '0, '0, '0);
    send_item(KIND_QUERY, 32'd105, -32'sd45, 32'd201, 1'b0, '0, '0, '0);
    send_item(KIND_QUERY, 32'd119, -32'sd36, 32'h7fff_ffff, 1'b0, '0, '0, '0);
    drain();
    // zero spacing, out-of-range point counts, fade window that starts below zero
    cfg_write(CFG_X_CELL, 32'd0);
    cfg_write(CFG_Y_CELL, 32'h8000_0000);
    cfg_write(CFG_POINTS, 32'd31);
    cfg_write(CFG_FADE_START, -32'sd100);
    cfg_write(CFG_FADE_END, 32'h7fff_ffff);
    send_item(KIND_QUERY, 32'd101, -32'sd49, 32'd1000, 1'b0, '0, '0, '0);
    send_item(KIND_QUERY, 32'd99, -32'sd51, -32'sd5, 1'b0, '0, '0, '0);
    drain();
    cfg_write(CFG_POINTS, 32'd0);
    cfg_write(CFG_ENABLE, 32'd0);
    send_item(KIND_QUERY, 32'd101, -32'sd49, 32'd0, 1'b0, '0, '0, '0);
    drain();
  endtask

  task automatic test_random(int n_items, int mode);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(KIND_WRITE, $urandom(), $urandom(), $urandom(), 1'($urandom()),
                  4'($urandom()), 4'($urandom()),
                  mode == 0 ? pick32() : $urandom_range(0, 8000) - 4000);
      else random_query(int'(p_pts) + 2);
    end
    drain();
  endtask

  task automatic random_setup(int mode);
    cfg_write(CFG_ENABLE, 32'd1);
    cfg_write(CFG_POINTS, $urandom_range(0, 31));
    if (mode == 0) begin
      cfg_write(CFG_X_ORIGIN, pick32());
      cfg_write(CFG_Y_ORIGIN, pick32());
      cfg_write(CFG_X_CELL, $urandom_range(0, 3) == 0 ? 32'h7fff_ffff : $urandom());
      cfg_write(CFG_Y_CELL, $urandom_range(0, 3) == 0 ? 32'h7fff_ffff : $urandom());
      cfg_write(CFG_FADE_START, 32'h8000_0000);
      cfg_write(CFG_FADE_END, $urandom());
    end else begin
      cfg_write(CFG_X_ORIGIN, $urandom_range(0, 2000) - 1000);
      cfg_write(CFG_Y_ORIGIN, $urandom_range(0, 2000) - 1000);
      cfg_write(CFG_X_CELL, $urandom_range(1, 300));
      cfg_write(CFG_Y_CELL, $urandom_range(1, 300));
      cfg_write(CFG_FADE_START, $urandom_range(0, 200) - 50);
      cfg_write(CFG_FADE_END, $urandom_range(200, 5000));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        @(negedge clk);
        rx_holdoff = 3000;
      end
      for (int i = 0; i < 8; i++) random_query(int'(p_pts));
    join
    drain();
  endtask

  initial begin
    foreach (mesh[i]) mesh[i] = '0;
    p_enable = 1'b0;
    p_x_org = 0;
    p_x_cell = 1;
    p_y_org = 0;
    p_y_cell = 1;
    p_pts = 2;
    p_fade_lo = 0;
    p_fade_hi = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed();
    for (int ph = 0; ph < 3; ph++) begin
      random_setup(ph % 2);
      fill_mesh(ph % 2);
      test_random(320, ph % 2);
    end
    test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_setup(1);
    test_random(200, 1);
    if (errors == 0 && corrections_due.size() == 0) begin
      $display("grid_bilinear_z_correction test passed");
    end else begin
      if (corrections_due.size() != 0)
        $error("%0d z_correction results never arrived", corrections_due.size());
      $display("grid_bilinear_z_correction test failed");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("grid_bilinear_z_correction test failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/gbz_pkg.sv
design/gbz_grid.sv
design/gbz_muldiv.sv
design/grid_bilinear_z_correction.sv
design/gbz_checker.sv
tb/sv/tb_grid_bilinear_z_correction.sv
